FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the bus decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/hmmd_pkg.sv
// Package with the types and constants of the memory map bus decoder.
`timescale 1ns / 1ps

package hmmd_pkg;

  typedef enum logic [2:0] {
    TgtInside  = 3'd0,
    TgtRom     = 3'd1,
    TgtCartRam = 3'd2,
    TgtIo      = 3'd3,
    TgtDropped = 3'd4
  } target_e;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } op_e;

  // Region boundaries of the bus address map.
  localparam logic [15:0] VideoBase    = 16'h8000;
  localparam logic [15:0] CartRamBase  = 16'hA000;
  localparam logic [15:0] WorkBase     = 16'hC000;
  localparam logic [15:0] EchoLast     = 16'hFDFF;
  localparam logic [15:0] SpriteLast   = 16'hFE9F;
  localparam logic [15:0] IoBase       = 16'hFF00;
  localparam logic [15:0] HighBase     = 16'hFF80;
  localparam logic [15:0] InterruptReg = 16'hFFFF;

  localparam logic [7:0] BlockedByte = 8'hFF;

  // Video RAM has a memory of its own. Work RAM, sprite RAM and high RAM
  // share a second one: work RAM in the lower half, sprite and high RAM
  // at the start of the upper half, indexed by address bits 8:0.
  localparam int unsigned VideoAw   = 13;
  localparam int unsigned MainAw    = 14;
  localparam int unsigned VideoDepth = 2 ** VideoAw;
  localparam int unsigned MainDepth  = 2 ** MainAw;

  typedef struct packed {
    logic                re;
    logic                we_video;
    logic                we_main;
    logic [MainAw-1:0]   index;
    logic [7:0]          wdata;
  } mem_req_t;

  typedef struct packed {
    target_e     target;
    logic [15:0] fwd_addr;
    logic        fwd_write;
    logic [7:0]  fwd_data;
    logic [7:0]  rd_const;
    logic        use_mem;
    logic        sel_video;
  } res_t;

endpackage

FILE: hdl/hmmd_in_if.sv
// Input channel of the bus decoder: one bus access per word.
`timescale 1ns / 1ps

interface hmmd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        video_ram_open;
  logic        sprite_ram_open;

  modport source (
    output valid, operation, address, write_data, video_ram_open, sprite_ram_open,
    input  ready
  );
  modport sink (
    input  valid, operation, address, write_data, video_ram_open, sprite_ram_open,
    output ready
  );
endinterface

FILE: hdl/hmmd_out_if.sv
// Output channel of the bus decoder: one decoded result per word.
`timescale 1ns / 1ps

interface hmmd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [2:0]  target;
  logic [15:0] forward_address;
  logic        forward_write;
  logic [7:0]  forward_data;

  modport source (
    output valid, read_data, target, forward_address, forward_write, forward_data,
    input  ready
  );
  modport sink (
    input  valid, read_data, target, forward_address, forward_write, forward_data,
    output ready
  );
endinterface

FILE: hdl/hmmd_decode.sv
// Address decoder: splits one bus access into a memory request and a result.
`timescale 1ns / 1ps

module hmmd_decode import hmmd_pkg::*; (
  input  logic        operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic        video_ram_open_i,
  input  logic        sprite_ram_open_i,
  output mem_req_t    req_o,
  output res_t        res_o
);

  logic wr;

  assign wr = (operation_i == OpWrite);

  always_comb begin
    req_o          = '0;
    req_o.index    = {1'b0, address_i[VideoAw-1:0]};
    req_o.wdata    = write_data_i;
    res_o          = '0;
    res_o.target   = TgtInside;

    if (address_i < VideoBase) begin
      res_o.target    = TgtRom;
      res_o.fwd_addr  = address_i;
      res_o.fwd_write = wr;
      res_o.fwd_data  = wr ? write_data_i : 8'h00;
    end else if (address_i < CartRamBase) begin
      if (!video_ram_open_i) begin
        if (wr) begin
          res_o.target = TgtDropped;
        end else begin
          res_o.rd_const = BlockedByte;
        end
      end else begin
        req_o.we_video  = wr;
        req_o.re        = !wr;
        res_o.use_mem   = !wr;
        res_o.sel_video = 1'b1;
      end
    end else if (address_i < WorkBase) begin
      res_o.target    = TgtCartRam;
      res_o.fwd_addr  = address_i - CartRamBase;
      res_o.fwd_write = wr;
      res_o.fwd_data  = wr ? write_data_i : 8'h00;
    end else if (address_i <= EchoLast) begin
      // Work RAM and its echo both index by the low 13 address bits.
      req_o.we_main = wr;
      req_o.re      = !wr;
      res_o.use_mem = !wr;
    end else if (address_i <= SpriteLast) begin
      req_o.index = {1'b1, {(MainAw-10){1'b0}}, address_i[8:0]};
      if (!sprite_ram_open_i) begin
        if (wr) begin
          res_o.target = TgtDropped;
        end else begin
          res_o.rd_const = BlockedByte;
        end
      end else begin
        req_o.we_main = wr;
        req_o.re      = !wr;
        res_o.use_mem = !wr;
      end
    end else if (address_i < IoBase) begin
      if (wr) begin
        res_o.target = TgtDropped;
      end else begin
        res_o.rd_const = sprite_ram_open_i ? 8'h00 : BlockedByte;
      end
    end else if (address_i < HighBase || address_i == InterruptReg) begin
      res_o.target    = TgtIo;
      res_o.fwd_addr  = address_i;
      res_o.fwd_write = wr;
      res_o.fwd_data  = wr ? write_data_i : 8'h00;
    end else begin
      req_o.index   = {1'b1, {(MainAw-10){1'b0}}, address_i[8:0]};
      req_o.we_main = wr;
      req_o.re      = !wr;
      res_o.use_mem = !wr;
    end
  end

endmodule

FILE: hdl/hmmd_store.sv
// Video memory and shared main memory with their clearing sweep after reset.
`timescale 1ns / 1ps

module hmmd_store import hmmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_req_t   req_i,
  output logic       busy_o,
  output logic [7:0] video_rdata_o,
  output logic [7:0] main_rdata_o
);

  logic [7:0] video_mem [VideoDepth];
  logic [7:0] main_mem  [MainDepth];

  logic [7:0]        video_rdata_q;
  logic [7:0]        main_rdata_q;
  logic              busy_q, busy_d;
  logic [MainAw-1:0] clr_cnt_q, clr_cnt_d;

  logic               video_we;
  logic [VideoAw-1:0] video_waddr;
  logic               main_we;
  logic [MainAw-1:0]  main_waddr;
  logic [7:0]         wdata;

  // The sweep owns both write ports until every entry holds zero.
  always_comb begin
    video_we    = busy_q | req_i.we_video;
    main_we     = busy_q | req_i.we_main;
    video_waddr = busy_q ? clr_cnt_q[VideoAw-1:0] : req_i.index[VideoAw-1:0];
    main_waddr  = busy_q ? clr_cnt_q : req_i.index;
    wdata       = busy_q ? 8'h00 : req_i.wdata;
  end

  always_comb begin
    busy_d    = busy_q;
    clr_cnt_d = clr_cnt_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (video_we) begin
      video_mem[video_waddr] <= wdata;
    end
    if (req_i.re) begin
      video_rdata_q <= video_mem[req_i.index[VideoAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_we) begin
      main_mem[main_waddr] <= wdata;
    end
    if (req_i.re) begin
      main_rdata_q <= main_mem[req_i.index];
    end
  end

  assign busy_o        = busy_q;
  assign video_rdata_o = video_rdata_q;
  assign main_rdata_o  = main_rdata_q;

endmodule

FILE: hdl/handheld_memory_map_bus_decoder_unit.sv
// Top level of the handheld console memory map decoder with its internal RAMs.
`timescale 1ns / 1ps

// Each input word is one processor bus access, a read or a write of a
// 16-bit address, and yields exactly one output word. Video RAM
// (0x8000-0x9FFF), work RAM (0xC000-0xDFFF, echoed at 0xE000-0xFDFF), sprite
// attribute RAM (0xFE00-0xFE9F) and high RAM (0xFF80-0xFFFE) are served from
// two internal synchronous memories: one for video RAM and one shared by the
// other three. Accesses to cartridge ROM, cartridge RAM (forwarded as an
// offset from 0xA000) and the I/O registers including 0xFFFF are passed on
// in the forward fields, and their read data must be supplied outside.
// A closed video or sprite RAM reads as 0xFF and drops writes, which then
// report target 4. The block takes one word per cycle unless its output is
// stalled: the memory read is issued in the cycle the word is accepted, and
// its registered data reaches the output together with the result in the
// cycle after acceptance. A new word is taken in the same cycle that the
// waiting result leaves; while a result is stalled on the output, no input
// word is taken. After reset the block accepts no word while a sweep writes
// zero to every entry of both memories, one entry per cycle.

`include "assert_macros.svh"

module handheld_memory_map_bus_decoder_unit import hmmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hmmd_in_if.sink     in_i,
  hmmd_out_if.source  out_o
);

  mem_req_t   dec_req;
  res_t       dec_res;
  mem_req_t   store_req;
  res_t       res_q;
  logic       out_valid_q, out_valid_d;
  logic       in_ready;
  logic       in_accept;
  logic       busy;
  logic [7:0] video_rdata;
  logic [7:0] main_rdata;

  hmmd_decode u_decode (
    .operation_i      (in_i.operation),
    .address_i        (in_i.address),
    .write_data_i     (in_i.write_data),
    .video_ram_open_i (in_i.video_ram_open),
    .sprite_ram_open_i(in_i.sprite_ram_open),
    .req_o            (dec_req),
    .res_o            (dec_res)
  );

  // A word is taken once the clearing sweep is done and the output register
  // is empty or is being emptied in the same cycle.
  assign in_ready  = !busy && (!out_valid_q || out_o.ready);
  assign in_accept = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Memory strobes fire only for an accepted word, so the read data
  // registers hold their value while a result is stalled.
  always_comb begin
    store_req          = dec_req;
    store_req.re       = dec_req.re & in_accept;
    store_req.we_video = dec_req.we_video & in_accept;
    store_req.we_main  = dec_req.we_main & in_accept;
  end

  hmmd_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (store_req),
    .busy_o       (busy),
    .video_rdata_o(video_rdata),
    .main_rdata_o (main_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= dec_res;
    end
  end

  // Stored bytes come straight from the memory read register; constant
  // answers (blocked, unusable, forwarded or written) come from res_q.
  assign out_o.valid           = out_valid_q;
  assign out_o.read_data       = res_q.use_mem ? (res_q.sel_video ? video_rdata : main_rdata)
                                               : res_q.rd_const;
  assign out_o.target          = res_q.target;
  assign out_o.forward_address = res_q.fwd_addr;
  assign out_o.forward_write   = res_q.fwd_write;
  assign out_o.forward_data    = res_q.fwd_data;

  // No word may enter while the memories are still being cleared.
  `ASSERT_ALWAYS(a_no_accept_while_clearing,
                 !(busy && in_i.valid && in_i.ready), "accept during clear")
  // An accepted word always produces a pending result in the next cycle.
  `ASSERT_CLKD(a_result_follows, (in_i.valid && in_i.ready) |=> out_valid_q, "result missing")
  // A memory read result is only ever served from inside the block.
  `ASSERT_CLKD(a_mem_inside,
               (out_valid_q && res_q.use_mem) |-> (res_q.target == TgtInside),
               "memory read with forward target")
  // Forwarded writes only leave through a forwarding target.
  `ASSERT_CLKD(a_fwd_target,
               (out_valid_q && res_q.fwd_write) |->
                 (res_q.target == TgtRom || res_q.target == TgtCartRam || res_q.target == TgtIo),
               "forward write on wrong target")
  // A pending result is not lost while the sink stalls.
  `ASSERT_CLKD(a_hold_result,
               (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(res_q)),
               "stalled result changed")

endmodule
